>>> hw/rtl/lpht_pkg.sv
`default_nettype none
package lpht_pkg;

    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;
    localparam int          OCC_W     = 11;
    localparam int          LIMIT_W   = 10;

    typedef enum logic [1:0] {
        CMD_INSTALL = 2'd0,
        CMD_LOOKUP  = 2'd1,
        CMD_DELETE  = 2'd2,
        CMD_IGNORE  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        TAG_EMPTY = 2'd0,
        TAG_LIVE  = 2'd1,
        TAG_TOMB  = 2'd2
    } t_tag;

    typedef enum logic [1:0] {
        FIND_MATCH,
        FIND_FREE,
        FIND_NONE
    } t_find;

    typedef enum logic [1:0] {
        F_IDLE,
        F_HASH,
        F_PUSH
    } t_fstate;

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_ADDR,
        B_CHECK,
        B_COMMIT
    } t_bstate;

    typedef struct packed {
        t_cmd        command;
        logic [63:0] key_bytes;
        logic [3:0]  key_length;
        logic [31:0] value;
    } t_req;

    typedef struct packed {
        logic        hit;
        logic [31:0] read_value;
        logic        table_full;
        logic        key_refused;
    } t_rsp;

    // classified transaction handed from front to back
    typedef struct packed {
        t_cmd        command;
        logic [63:0] key;
        logic [3:0]  key_length;
        logic [31:0] value;
        logic [31:0] hash;
        logic        refused;
    } t_job;

    typedef struct packed {
        logic [63:0] key;
        logic [3:0]  key_length;
        logic [31:0] value;
    } t_slot;

endpackage
`default_nettype wire

>>> hw/rtl/lpht_front.sv
`default_nettype none
module lpht_front
    import lpht_pkg::*;
#(
    parameter int KEY_BYTES = 8
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    input  wire t_req i_req,
    output logic      o_busy,
    output logic      o_push,
    output t_job      o_job,
    input  wire logic i_full
);

    t_fstate     r_state, n_state;
    t_job        r_job, n_job;
    logic [2:0]  r_idx, n_idx;
    logic [3:0]  len_c;
    logic [63:0] key_m;
    logic [31:0] mix;
    logic [63:0] prod;

    always_comb begin
        len_c = (i_req.key_length > 4'(KEY_BYTES)) ? 4'(KEY_BYTES) : i_req.key_length;
        for (int b = 0; b < 8; b++) begin
            key_m[8*b +: 8] = (4'(b) < len_c) ? i_req.key_bytes[8*b +: 8] : 8'd0;
        end
        mix  = r_job.hash ^ {24'd0, r_job.key[{r_idx, 3'd0} +: 8]};
        prod = mix * FNV_PRIME;
    end

    always_comb begin
        n_state = r_state;
        n_job   = r_job;
        n_idx   = r_idx;
        o_push  = 1'b0;
        unique case (r_state)
            F_IDLE: begin
                if (i_start) begin
                    n_job.command    = i_req.command;
                    n_job.key        = key_m;
                    n_job.key_length = len_c;
                    n_job.value      = i_req.value;
                    n_job.hash       = FNV_BASIS;
                    n_job.refused    = (len_c == 4'd0);
                    n_idx            = 3'd0;
                    if (len_c == 4'd0 || i_req.command == CMD_IGNORE) begin
                        n_state = F_PUSH;
                    end else begin
                        n_state = F_HASH;
                    end
                end
            end
            F_HASH: begin
                n_job.hash = prod[31:0];
                n_idx      = r_idx + 3'd1;
                if ({1'b0, r_idx} == r_job.key_length - 4'd1) begin
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!i_full) begin
                    o_push  = 1'b1;
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_idx   <= 3'd0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
        r_job <= n_job;
    end

    assign o_busy = (r_state != F_IDLE);
    assign o_job  = r_job;

endmodule
`default_nettype wire

>>> hw/rtl/lpht_queue.sv
`default_nettype none
module lpht_queue
    import lpht_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    output logic      o_full,
    output logic      o_valid,
    output t_job      o_job,
    input  wire logic i_pop
);

    // two-entry ring
    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
        if (i_push) r_mem[r_wp] <= i_job;
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rp];

endmodule
`default_nettype wire

>>> hw/rtl/lpht_back.sv
`default_nettype none
module lpht_back
    import lpht_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [LIMIT_W-1:0] i_load_limit,
    input  wire logic               i_valid,
    input  wire t_job               i_job,
    output logic                    o_pop,
    output logic                    o_clearing,
    output logic                    o_done,
    output t_rsp                    o_rsp
);

    localparam int AW = $clog2(TABLE_DEPTH);

    t_slot           mem_slot [TABLE_DEPTH];
    t_tag            mem_tag  [TABLE_DEPTH];
    t_slot           r_rd_slot;
    t_tag            r_rd_tag;

    t_bstate         r_state, n_state;
    t_job            r_job, n_job;
    logic [AW-1:0]   r_addr, n_addr;
    logic [AW:0]     r_cnt, n_cnt;
    logic            r_have_tomb, n_have_tomb;
    logic [AW-1:0]   r_tomb, n_tomb;
    logic [AW-1:0]   r_where, n_where;
    t_find           r_find, n_find;
    logic [31:0]     r_val, n_val;
    logic [OCC_W-1:0] r_occ, n_occ;
    logic            r_done, n_done;
    t_rsp            r_rsp, n_rsp;

    logic            slot_we, tag_we;
    logic [AW-1:0]   tag_waddr;
    t_tag            tag_wdata;
    logic            fresh, over;

    always_comb begin
        n_state     = r_state;
        n_job       = r_job;
        n_addr      = r_addr;
        n_cnt       = r_cnt;
        n_have_tomb = r_have_tomb;
        n_tomb      = r_tomb;
        n_where     = r_where;
        n_find      = r_find;
        n_val       = r_val;
        n_occ       = r_occ;
        n_done      = 1'b0;
        n_rsp       = '0;
        o_pop       = 1'b0;
        slot_we     = 1'b0;
        tag_we      = 1'b0;
        tag_waddr   = r_addr;
        tag_wdata   = TAG_EMPTY;
        fresh       = ~r_have_tomb;
        over        = ({1'b0, r_occ} + 12'd1) > {2'd0, i_load_limit};
        unique case (r_state)
            B_CLEAR: begin
                tag_we = 1'b1;
                n_addr = r_addr + 1'b1;
                if (r_addr == AW'(TABLE_DEPTH - 1)) n_state = B_IDLE;
            end
            B_IDLE: begin
                if (i_valid) begin
                    o_pop       = 1'b1;
                    n_job       = i_job;
                    n_addr      = i_job.hash[AW-1:0];
                    n_cnt       = '0;
                    n_have_tomb = 1'b0;
                    n_val       = '0;
                    if (i_job.refused) begin
                        n_done            = 1'b1;
                        n_rsp.key_refused = 1'b1;
                    end else if (i_job.command == CMD_IGNORE) begin
                        n_done = 1'b1;
                    end else begin
                        n_state = B_ADDR;
                    end
                end
            end
            B_ADDR: n_state = B_CHECK;
            B_CHECK: begin
                priority if (r_rd_tag == TAG_EMPTY) begin
                    n_find  = FIND_FREE;
                    n_where = r_have_tomb ? r_tomb : r_addr;
                    n_state = B_COMMIT;
                end else if (r_rd_tag == TAG_LIVE
                             && r_rd_slot.key_length == r_job.key_length
                             && r_rd_slot.key == r_job.key) begin
                    n_find  = FIND_MATCH;
                    n_where = r_addr;
                    n_val   = r_rd_slot.value;
                    n_state = B_COMMIT;
                end else begin
                    if (r_rd_tag != TAG_LIVE && !r_have_tomb) begin
                        n_have_tomb = 1'b1;
                        n_tomb      = r_addr;
                    end
                    n_cnt = r_cnt + 1'b1;
                    if (n_cnt == (AW+1)'(TABLE_DEPTH)) begin
                        n_find  = n_have_tomb ? FIND_FREE : FIND_NONE;
                        n_where = n_tomb;
                        n_state = B_COMMIT;
                    end else begin
                        n_addr  = r_addr + 1'b1;
                        n_state = B_ADDR;
                    end
                end
            end
            B_COMMIT: begin
                n_done    = 1'b1;
                n_state   = B_IDLE;
                tag_waddr = r_where;
                unique case (r_job.command)
                    CMD_INSTALL: begin
                        unique case (r_find)
                            FIND_MATCH: slot_we = 1'b1;
                            FIND_NONE:  n_rsp.table_full = 1'b1;
                            FIND_FREE: begin
                                if (fresh && over) begin
                                    n_rsp.table_full = 1'b1;
                                end else begin
                                    slot_we   = 1'b1;
                                    tag_we    = 1'b1;
                                    tag_wdata = TAG_LIVE;
                                    n_rsp.hit = 1'b1;
                                    if (fresh) n_occ = r_occ + 1'b1;
                                end
                            end
                            default: ;
                        endcase
                    end
                    CMD_LOOKUP: begin
                        if (r_find == FIND_MATCH) begin
                            n_rsp.hit        = 1'b1;
                            n_rsp.read_value = r_val;
                        end
                    end
                    CMD_DELETE: begin
                        if (r_find == FIND_MATCH) begin
                            n_rsp.hit = 1'b1;
                            tag_we    = 1'b1;
                            tag_wdata = TAG_TOMB;
                        end
                    end
                    default: ;
                endcase
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (slot_we) begin
            mem_slot[r_where] <= '{key: r_job.key, key_length: r_job.key_length,
                                   value: r_job.value};
        end
        if (tag_we) mem_tag[tag_waddr] <= tag_wdata;
        r_rd_slot <= mem_slot[r_addr];
        r_rd_tag  <= mem_tag[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_CLEAR;
            r_addr      <= '0;
            r_cnt       <= '0;
            r_have_tomb <= 1'b0;
            r_find      <= FIND_NONE;
            r_occ       <= '0;
            r_done      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_cnt       <= n_cnt;
            r_have_tomb <= n_have_tomb;
            r_find      <= n_find;
            r_occ       <= n_occ;
            r_done      <= n_done;
        end
        r_job   <= n_job;
        r_tomb  <= n_tomb;
        r_where <= n_where;
        r_val   <= n_val;
        r_rsp   <= n_rsp;
    end

    assign o_clearing = (r_state == B_CLEAR);
    assign o_done     = r_done;
    assign o_rsp      = r_rsp;

endmodule
`default_nettype wire

>>> hw/rtl/linear_probe_hash_table_top.sv
`default_nettype none
// Key/value table with linear probing and FNV-1a hashing. A transaction is
// taken when start is high and busy is low; its result appears on o_rsp for
// exactly one cycle with o_done high and cannot be held off, so the receiver
// must take it then. The front hashes one key byte per cycle (one 32x32
// multiply), then pushes the job, staying busy while the queue is full; an
// empty key or ignored command is pushed without hashing. The back walks the
// slot memory one probed slot at a time, each probe a registered read
// (B_ADDR) then a compare (B_CHECK), after a pop in B_IDLE and before a
// commit in B_COMMIT; the result is registered and shows in the cycle after
// the commit. Empty keys and ignored commands are answered from B_IDLE
// without probing. A two-entry queue sits between front and back so hashing
// of the next transaction overlaps probing of the current one. After reset
// the back runs a clearing pass over every tag memory entry; busy stays high
// until it ends. Configuration (load_limit) is written through i_cfg_we /
// i_cfg_wdata; the user must do so only while idle, as the block does not check.
module linear_probe_hash_table_top
    import lpht_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024,
    parameter int KEY_BYTES   = 8
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire t_req               i_req,
    input  wire logic               i_cfg_we,
    input  wire logic [LIMIT_W-1:0] i_cfg_wdata,
    output logic                    o_done,
    output t_rsp                    o_rsp
);

    logic [LIMIT_W-1:0] r_load_limit;
    logic               front_busy, clearing;
    logic               push, q_full, q_valid, pop;
    t_job               f_job, q_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_limit <= LIMIT_W'(768);
        end else if (i_cfg_we) begin
            r_load_limit <= i_cfg_wdata;
        end
    end

    // hold off new transactions while the front is busy or the back is clearing
    assign busy = front_busy | clearing;

    lpht_front #(.KEY_BYTES(KEY_BYTES)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start & ~clearing),
        .i_req   (i_req),
        .o_busy  (front_busy),
        .o_push  (push),
        .o_job   (f_job),
        .i_full  (q_full)
    );

    lpht_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (f_job),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (q_job),
        .i_pop   (pop)
    );

    lpht_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load_limit (r_load_limit),
        .i_valid      (q_valid),
        .i_job        (q_job),
        .o_pop        (pop),
        .o_clearing   (clearing),
        .o_done       (o_done),
        .o_rsp        (o_rsp)
    );

endmodule
`default_nettype wire
